>>> src/rpbp_pkg.sv
package rpbp_pkg;

  // coordinate and weight formats
  localparam int COORD_BITS       = 20;
  localparam int WEIGHT_FRAC_BITS = 16;

  // derived widths
  localparam int VEC_W  = 3 * COORD_BITS;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int HQ_W   = 2 * COORD_BITS + 3;
  localparam int SPL_W  = (HQ_W + 1) / 2;
  localparam int SHI_W  = HQ_W - SPL_W;
  localparam int DOT_W  = 3 * COORD_BITS + 6;
  localparam int TCH_W  = DOT_W / 3;
  localparam int PROD_W = DOT_W + COORD_BITS;
  localparam int SCL_W  = DOT_W + WEIGHT_FRAC_BITS + 2;
  localparam int REM_W  = ((PROD_W > DOT_W + WEIGHT_FRAC_BITS) ?
                           PROD_W : DOT_W + WEIGHT_FRAC_BITS) + 3;
  localparam int QUO_W  = (COORD_BITS + 2 > WEIGHT_FRAC_BITS + 1) ?
                          COORD_BITS + 2 : WEIGHT_FRAC_BITS + 1;
  localparam int WS_W   = WEIGHT_FRAC_BITS + 1;
  localparam int WF_W   = WEIGHT_FRAC_BITS + 2;

  // divider lanes: three hit coordinates, then the two weights
  localparam int LANES  = 5;
  localparam int LANE_U = 3;
  localparam int LANE_V = 4;

  typedef logic        [VEC_W-1:0]  vec_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [HQ_W-1:0]   hq_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [REM_W-1:0]  rem_t;
  typedef logic        [QUO_W-1:0]  quo_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [WS_W-1:0] W_ONE = WS_W'(1) << WEIGHT_FRAC_BITS;

  // per-item flags and query point carried alongside the divider
  typedef struct packed {
    logic         degen;
    logic         oor;
    logic [1:0]   wone;
    logic [2:0]   neg;
    coord_t [2:0] pnt;
  } side_t;

  function automatic coord_t coord_of(vec_t v, int k);
    return v[k*COORD_BITS +: COORD_BITS];
  endfunction

  function automatic int axis_nxt(int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

endpackage

>>> src/rpbp_if.sv
interface rpbp_in_if;
  logic                      valid;
  logic                      ready;
  logic [rpbp_pkg::VEC_W-1:0] vertex_a;
  logic [rpbp_pkg::VEC_W-1:0] vertex_b;
  logic [rpbp_pkg::VEC_W-1:0] vertex_c;
  logic [rpbp_pkg::VEC_W-1:0] query_point;
  logic [rpbp_pkg::VEC_W-1:0] line_direction;

  modport source (output valid, vertex_a, vertex_b, vertex_c, query_point,
                  line_direction, input ready);
  modport sink (input valid, vertex_a, vertex_b, vertex_c, query_point,
                line_direction, output ready);
endinterface

interface rpbp_out_if;
  logic                              valid;
  logic                              ready;
  logic [rpbp_pkg::VEC_W-1:0]        hit_point;
  logic signed [rpbp_pkg::WF_W-1:0]  weight_first;
  logic [rpbp_pkg::WS_W-1:0]         weight_second;
  logic [rpbp_pkg::WS_W-1:0]         weight_third;
  logic                              out_of_range;
  logic                              degenerate;

  modport source (output valid, hit_point, weight_first, weight_second,
                  weight_third, out_of_range, degenerate, input ready);
  modport sink (input valid, hit_point, weight_first, weight_second,
                weight_third, out_of_range, degenerate, output ready);
endinterface

>>> src/ray_plane_barycentric_projection.sv
// Intersects the line through query_point along line_direction with the plane
// of triangle (vertex_a, vertex_b, vertex_c) and returns the hit point and
// the barycentric weights. Fully pipelined: one transfer in and one out per
// cycle unless the output stalls, through 5 stages of cross/dot products,
// 5 of sign normalisation, rounding and scaling, 22 restoring-division
// stages producing one quotient bit each, and the output register. A stall
// on the output holds the whole pipeline; in_ch.ready follows out_ch.ready
// whenever the output register is full. A zero determinant gives
// degenerate = 1 and zero in every other field.
module ray_plane_barycentric_projection (
  input  logic        clk,
  input  logic        rst_n,
  rpbp_in_if.sink     in_ch,
  rpbp_out_if.source  out_ch
);
  import rpbp_pkg::*;

  logic   adv;
  logic   fr_v, pr_v, dv_v;
  dot_t   det, unum, vnum, tnum;
  coord_t dir [3];
  coord_t pnt [3];
  rem_t   num [LANES];
  rem_t   den;
  side_t  pr_side, dv_side;
  quo_t   quo [LANES];

  logic                   out_v_r;
  logic [VEC_W-1:0]       hit_r, hit_nxt;
  logic signed [WF_W-1:0] wf_r, wf_nxt;
  logic [WS_W-1:0]        wu_r, wu_nxt;
  logic [WS_W-1:0]        wv_r, wv_nxt;
  logic                   oor_r, oor_nxt;
  logic                   dg_r;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  rpbp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (in_ch.valid),
    .va    (in_ch.vertex_a),
    .vb    (in_ch.vertex_b),
    .vc    (in_ch.vertex_c),
    .vp    (in_ch.query_point),
    .vd    (in_ch.line_direction),
    .out_v (fr_v),
    .det   (det),
    .unum  (unum),
    .vnum  (vnum),
    .tnum  (tnum),
    .dir   (dir),
    .pnt   (pnt)
  );

  rpbp_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (fr_v),
    .det   (det),
    .unum  (unum),
    .vnum  (vnum),
    .tnum  (tnum),
    .dir   (dir),
    .pnt   (pnt),
    .out_v (pr_v),
    .num   (num),
    .den   (den),
    .side  (pr_side)
  );

  rpbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (pr_v),
    .num      (num),
    .den      (den),
    .side_in  (pr_side),
    .out_v    (dv_v),
    .quo      (quo),
    .side_out (dv_side)
  );

  // hit point: signed quotient plus query point, saturated
  always_comb begin
    logic signed [COORD_BITS+2:0] xv;
    coord_t                       xc;
    hit_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      xv = $signed({2'b00, quo[k][COORD_BITS:0]});
      if (dv_side.neg[k]) xv = -xv;
      xv = xv + $signed(dv_side.pnt[k]);
      if (|quo[k][QUO_W-1:COORD_BITS+1]) begin
        xc = dv_side.neg[k] ? COORD_MIN : COORD_MAX;
      end else if (xv > COORD_MAX) begin
        xc = COORD_MAX;
      end else if (xv < COORD_MIN) begin
        xc = COORD_MIN;
      end else begin
        xc = xv[COORD_BITS-1:0];
      end
      if (!dv_side.degen) hit_nxt[k*COORD_BITS +: COORD_BITS] = xc;
    end
  end

  // weights
  always_comb begin
    wu_nxt  = dv_side.wone[0] ? W_ONE : quo[LANE_U][WS_W-1:0];
    wv_nxt  = dv_side.wone[1] ? W_ONE : quo[LANE_V][WS_W-1:0];
    wf_nxt  = $signed({1'b0, W_ONE}) - $signed({1'b0, wu_nxt})
              - $signed({1'b0, wv_nxt});
    oor_nxt = dv_side.oor;
    if (dv_side.degen) begin
      wu_nxt  = '0;
      wv_nxt  = '0;
      wf_nxt  = '0;
      oor_nxt = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= hit_nxt;
      wf_r  <= wf_nxt;
      wu_r  <= wu_nxt;
      wv_r  <= wv_nxt;
      oor_r <= oor_nxt;
      dg_r  <= dv_side.degen;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.hit_point     = hit_r;
  assign out_ch.weight_first  = wf_r;
  assign out_ch.weight_second = wu_r;
  assign out_ch.weight_third  = wv_r;
  assign out_ch.out_of_range  = oor_r;
  assign out_ch.degenerate    = dg_r;

endmodule

>>> src/rpbp_front.sv
module rpbp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  rpbp_pkg::vec_t         va,
  input  rpbp_pkg::vec_t         vb,
  input  rpbp_pkg::vec_t         vc,
  input  rpbp_pkg::vec_t         vp,
  input  rpbp_pkg::vec_t         vd,
  output logic                   out_v,
  output rpbp_pkg::dot_t         det,
  output rpbp_pkg::dot_t         unum,
  output rpbp_pkg::dot_t         vnum,
  output rpbp_pkg::dot_t         tnum,
  output rpbp_pkg::coord_t       dir [3],
  output rpbp_pkg::coord_t       pnt [3]
);
  import rpbp_pkg::*;

  logic   v_r [1:5];
  coord_t n_r [1:4][3];
  coord_t p_r [1:4][3];
  coord_t n_nxt [3];
  coord_t p_nxt [3];

  diff_t e1_r [1:3][3];
  diff_t e2_r [1:3][3];
  diff_t s_r  [1:3][3];
  diff_t e1_nxt [3];
  diff_t e2_nxt [3];
  diff_t s_nxt  [3];

  hq_t hp_r [3][2];
  hq_t qp_r [3][2];
  hq_t hp_nxt [3][2];
  hq_t qp_nxt [3][2];
  hq_t h_r [3];
  hq_t q_r [3];
  hq_t h_nxt [3];
  hq_t q_nxt [3];

  dot_t lo_r [4][3];
  dot_t hi_r [4][3];
  dot_t lo_nxt [4][3];
  dot_t hi_nxt [4][3];
  dot_t dot_r [4];
  dot_t dot_nxt [4];
  coord_t n5_r [3];
  coord_t p5_r [3];

  // vertex differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_nxt[k]  = coord_of(vd, k);
      p_nxt[k]  = coord_of(vp, k);
      e1_nxt[k] = diff_t'(coord_of(vb, k)) - diff_t'(coord_of(va, k));
      e2_nxt[k] = diff_t'(coord_of(vc, k)) - diff_t'(coord_of(va, k));
      s_nxt[k]  = diff_t'(coord_of(vp, k)) - diff_t'(coord_of(va, k));
    end
  end

  // cross product terms: h = dir x e2, q = s x e1
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hp_nxt[k][0] = n_r[1][axis_nxt(k)] * e2_r[1][axis_nxt(axis_nxt(k))];
      hp_nxt[k][1] = n_r[1][axis_nxt(axis_nxt(k))] * e2_r[1][axis_nxt(k)];
      qp_nxt[k][0] = s_r[1][axis_nxt(k)] * e1_r[1][axis_nxt(axis_nxt(k))];
      qp_nxt[k][1] = s_r[1][axis_nxt(axis_nxt(k))] * e1_r[1][axis_nxt(k)];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      h_nxt[k] = hp_r[k][0] - hp_r[k][1];
      q_nxt[k] = qp_r[k][0] - qp_r[k][1];
    end
  end

  // dot product terms, wide operand split in two halves
  always_comb begin
    diff_t aop [4][3];
    hq_t   bop [4][3];
    for (int k = 0; k < 3; k++) begin
      aop[0][k] = e1_r[3][k];
      bop[0][k] = h_r[k];
      aop[1][k] = s_r[3][k];
      bop[1][k] = h_r[k];
      aop[2][k] = diff_t'(n_r[3][k]);
      bop[2][k] = q_r[k];
      aop[3][k] = e2_r[3][k];
      bop[3][k] = q_r[k];
    end
    for (int d = 0; d < 4; d++) begin
      for (int k = 0; k < 3; k++) begin
        lo_nxt[d][k] = aop[d][k] * $signed({1'b0, bop[d][k][SPL_W-1:0]});
        hi_nxt[d][k] = aop[d][k] * $signed(bop[d][k][HQ_W-1:SPL_W]);
      end
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      dot_nxt[d] = '0;
      for (int k = 0; k < 3; k++) begin
        dot_nxt[d] = dot_nxt[d] + (hi_r[d][k] <<< SPL_W) + lo_r[d][k];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= 5; j++) v_r[j] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_v;
      for (int j = 2; j <= 5; j++) v_r[j] <= v_r[j-1];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[1]  <= n_nxt;
      p_r[1]  <= p_nxt;
      e1_r[1] <= e1_nxt;
      e2_r[1] <= e2_nxt;
      s_r[1]  <= s_nxt;
      for (int j = 2; j <= 4; j++) begin
        n_r[j] <= n_r[j-1];
        p_r[j] <= p_r[j-1];
      end
      for (int j = 2; j <= 3; j++) begin
        e1_r[j] <= e1_r[j-1];
        e2_r[j] <= e2_r[j-1];
        s_r[j]  <= s_r[j-1];
      end
      hp_r  <= hp_nxt;
      qp_r  <= qp_nxt;
      h_r   <= h_nxt;
      q_r   <= q_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      dot_r <= dot_nxt;
      n5_r  <= n_r[4];
      p5_r  <= p_r[4];
    end
  end

  assign out_v = v_r[5];
  assign det   = dot_r[0];
  assign unum  = dot_r[1];
  assign vnum  = dot_r[2];
  assign tnum  = dot_r[3];
  assign dir   = n5_r;
  assign pnt   = p5_r;

endmodule

>>> src/rpbp_prep.sv
module rpbp_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  rpbp_pkg::dot_t    det,
  input  rpbp_pkg::dot_t    unum,
  input  rpbp_pkg::dot_t    vnum,
  input  rpbp_pkg::dot_t    tnum,
  input  rpbp_pkg::coord_t  dir [3],
  input  rpbp_pkg::coord_t  pnt [3],
  output logic              out_v,
  output rpbp_pkg::rem_t    num [rpbp_pkg::LANES],
  output rpbp_pkg::rem_t    den,
  output rpbp_pkg::side_t   side
);
  import rpbp_pkg::*;

  logic v_r [1:5];

  // stage 1: sign normalisation
  dot_t   d1_r, u1_r, w1_r, t1_r;
  logic   dg1_r;
  coord_t n1_r [3];
  coord_t p1_r [3];
  dot_t   d1_nxt, u1_nxt, w1_nxt, t1_nxt;

  // stage 2: weight checks and hit products
  dot_t   d2_r;
  rem_t   wn2_r [2];
  side_t  sd2_r;
  prod_t  pp_r [3][3];
  rem_t   wn2_nxt [2];
  side_t  sd2_nxt;
  prod_t  pp_nxt [3][3];

  // stage 3..5
  dot_t   d3_r, d4_r;
  rem_t   wn3_r [2];
  rem_t   wn4_r [2];
  side_t  sd3_r, sd4_r;
  prod_t  pr3_r [3];
  prod_t  pr3_nxt [3];
  logic [PROD_W-1:0] mg4_r [3];
  logic [PROD_W-1:0] mg4_nxt [3];
  rem_t   num5_r [LANES];
  rem_t   den5_r;
  side_t  sd5_r;
  rem_t   num5_nxt [LANES];

  always_comb begin
    d1_nxt = det[DOT_W-1] ? -det  : det;
    u1_nxt = det[DOT_W-1] ? -unum : unum;
    w1_nxt = det[DOT_W-1] ? -vnum : vnum;
    t1_nxt = det[DOT_W-1] ? -tnum : tnum;
  end

  // tolerance flag, clamp decision and dividend of each weight
  always_comb begin
    logic signed [SCL_W-1:0] sc;
    logic signed [SCL_W-1:0] lo_b;
    logic signed [SCL_W-1:0] hi_b;
    logic signed [SCL_W-1:0] dx;
    logic signed [TCH_W:0]   ch;
    dot_t                    wn;
    logic                    wz;
    sd2_nxt       = '0;
    sd2_nxt.degen = dg1_r;
    dx   = SCL_W'(d1_r);
    lo_b = -dx;
    hi_b = (dx <<< WEIGHT_FRAC_BITS) + dx;
    for (int w = 0; w < 2; w++) begin
      wn = (w == 0) ? u1_r : w1_r;
      sc = SCL_W'(wn);
      sc = sc <<< WEIGHT_FRAC_BITS;
      if (sc < lo_b || sc > hi_b) sd2_nxt.oor = 1'b1;
      wz = (wn[DOT_W-1] == 1'b1) || (wn == '0);
      sd2_nxt.wone[w] = !wz && (wn >= d1_r);
      if (wz || sd2_nxt.wone[w] || dg1_r) begin
        wn2_nxt[w] = '0;
      end else begin
        wn2_nxt[w] = (rem_t'(wn) << (WEIGHT_FRAC_BITS + 1)) + rem_t'(d1_r);
      end
    end
    for (int k = 0; k < 3; k++) begin
      sd2_nxt.pnt[k] = p1_r[k];
      for (int c = 0; c < 3; c++) begin
        if (c == 2) begin
          ch = {t1_r[DOT_W-1], t1_r[DOT_W-1 -: TCH_W]};
        end else begin
          ch = {1'b0, t1_r[c*TCH_W +: TCH_W]};
        end
        pp_nxt[k][c] = ch * n1_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr3_nxt[k] = (pp_r[k][2] <<< (2*TCH_W)) + (pp_r[k][1] <<< TCH_W) + pp_r[k][0];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mg4_nxt[k] = pr3_r[k][PROD_W-1] ? PROD_W'(-pr3_r[k]) : PROD_W'(pr3_r[k]);
    end
  end

  // rounding dividends: 2|n| + d over 2d
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num5_nxt[k] = (rem_t'(mg4_r[k]) << 1) + rem_t'(d4_r);
    end
    num5_nxt[LANE_U] = wn4_r[0];
    num5_nxt[LANE_V] = wn4_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 1; j <= 5; j++) v_r[j] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_v;
      for (int j = 2; j <= 5; j++) v_r[j] <= v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r  <= d1_nxt;
      u1_r  <= u1_nxt;
      w1_r  <= w1_nxt;
      t1_r  <= t1_nxt;
      dg1_r <= (det == '0);
      n1_r  <= dir;
      p1_r  <= pnt;
      d2_r  <= d1_r;
      wn2_r <= wn2_nxt;
      sd2_r <= sd2_nxt;
      pp_r  <= pp_nxt;
      d3_r  <= d2_r;
      wn3_r <= wn2_r;
      sd3_r <= sd2_r;
      pr3_r <= pr3_nxt;
      d4_r  <= d3_r;
      wn4_r <= wn3_r;
      mg4_r <= mg4_nxt;
      sd4_r.degen <= sd3_r.degen;
      sd4_r.oor   <= sd3_r.oor;
      sd4_r.wone  <= sd3_r.wone;
      sd4_r.pnt   <= sd3_r.pnt;
      for (int k = 0; k < 3; k++) sd4_r.neg[k] <= pr3_r[k][PROD_W-1];
      num5_r <= num5_nxt;
      den5_r <= rem_t'(d4_r) << 1;
      sd5_r  <= sd4_r;
    end
  end

  assign out_v = v_r[5];
  assign num   = num5_r;
  assign den   = den5_r;
  assign side  = sd5_r;

endmodule

>>> src/rpbp_div.sv
module rpbp_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_v,
  input  rpbp_pkg::rem_t   num [rpbp_pkg::LANES],
  input  rpbp_pkg::rem_t   den,
  input  rpbp_pkg::side_t  side_in,
  output logic             out_v,
  output rpbp_pkg::quo_t   quo [rpbp_pkg::LANES],
  output rpbp_pkg::side_t  side_out
);
  import rpbp_pkg::*;

  logic  v_r    [QUO_W];
  rem_t  rem_r  [QUO_W][LANES];
  quo_t  quo_r  [QUO_W][LANES];
  rem_t  den_r  [QUO_W];
  side_t side_r [QUO_W];

  // restoring division, one quotient bit per stage, msb first
  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    localparam int BIT = QUO_W - 1 - g;
    logic  v_in;
    rem_t  rem_in [LANES];
    quo_t  quo_in [LANES];
    rem_t  den_in;
    side_t side_st;
    rem_t  rem_nxt [LANES];
    quo_t  quo_nxt [LANES];

    if (g == 0) begin : g_head
      assign v_in    = in_v;
      assign rem_in  = num;
      assign den_in  = den;
      assign side_st = side_in;
      always_comb begin
        for (int l = 0; l < LANES; l++) quo_in[l] = '0;
      end
    end else begin : g_body
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign den_in  = den_r[g-1];
      assign side_st = side_r[g-1];
    end

    always_comb begin
      rem_t dsh;
      dsh = den_in << BIT;
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_nxt[l] = rem_in[l] - dsh;
          quo_nxt[l] = quo_in[l] | (quo_t'(1) << BIT);
        end else begin
          rem_nxt[l] = rem_in[l];
          quo_nxt[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[g]  <= rem_nxt;
        quo_r[g]  <= quo_nxt;
        den_r[g]  <= den_in;
        side_r[g] <= side_st;
      end
    end
  end

  assign out_v    = v_r[QUO_W-1];
  assign quo      = quo_r[QUO_W-1];
  assign side_out = side_r[QUO_W-1];

endmodule
